>>> src/stwf_pkg.sv
// Shared types and constants for the service triple wildcard filter.
// Used by stwf_ctrl, service_triple_wildcard_filter and its checker.
// No dependencies.
package stwf_pkg;

  // One identifier field and one stored entry {network, stream, service}
  localparam int unsigned FieldW = 16;
  localparam int unsigned EntryW = 3 * FieldW;

  // Request opcodes; the unused code behaves as a lookup
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_LOOKED  = 3'd0,
    ST_INSERT  = 3'd1,
    ST_COVERED = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  // One result
  typedef struct packed {
    logic    matched;
    status_e status;
  } res_t;

  // A stored zero field is a wildcard
  function automatic logic field_covers(logic [FieldW-1:0] stored,
                                        logic [FieldW-1:0] query);
    return (stored == '0) || (stored == query);
  endfunction

  // Entry layout: network in the top field, service in the bottom one
  function automatic logic entry_covers(logic [EntryW-1:0] entry,
                                        logic [EntryW-1:0] query);
    return field_covers(entry[3*FieldW-1:2*FieldW], query[3*FieldW-1:2*FieldW]) &&
           field_covers(entry[2*FieldW-1:FieldW],   query[2*FieldW-1:FieldW]) &&
           field_covers(entry[FieldW-1:0],          query[FieldW-1:0]);
  endfunction

endpackage

>>> src/stwf_store.sv
// Entry memory of the filter table: one write port, one read port,
// read data registered. No package dependency.
module stwf_store #(
  parameter int unsigned Depth  = 32,
  parameter int unsigned AddrW  = 5,
  parameter int unsigned DataW  = 48
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  // Synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/stwf_ctrl.sv
// Request sequencer of the filter: scans the entry memory one entry a
// cycle, decides the result, appends entries and holds the output register.
// Depends on stwf_pkg.
module stwf_ctrl #(
  parameter int unsigned Entries = 32,
  parameter int unsigned IdxW    = 5,
  parameter int unsigned FillW   = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [1:0]                  req_op_i,
  input  logic [stwf_pkg::EntryW-1:0] req_key_i,
  // entry memory
  output logic                        mem_we_o,
  output logic [IdxW-1:0]             mem_waddr_o,
  output logic [stwf_pkg::EntryW-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [IdxW-1:0]             mem_raddr_o,
  input  logic [stwf_pkg::EntryW-1:0] mem_rdata_i,
  // result side
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output stwf_pkg::res_t              res_o
);
  import stwf_pkg::*;

  state_e              state_q, state_d;
  logic [1:0]          op_q, op_d;
  logic [EntryW-1:0]   key_q, key_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [FillW-1:0]    rd_idx_q, rd_idx_d;
  logic                rd_vld_q;
  logic                hit_q, hit_d;
  res_t                res_q, res_d;
  logic                out_vld_q, out_vld_d;
  res_t                out_res_q, out_res_d;

  logic                accept;
  logic                rd_en;
  logic                scan_done;
  logic                out_free;

  assign accept    = req_valid_i && req_ready_o;
  assign rd_en     = (state_q == S_SCAN) && !hit_q && (rd_idx_q < fill_q);
  assign scan_done = (state_q == S_SCAN) && !rd_en && !rd_vld_q;
  assign out_free  = !out_vld_q || res_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (req_op_i == OP_CLEAR) ? S_FIN : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_ready_o = 1'b0;
    mem_re_o    = 1'b0;
    unique case (state_q)
      S_IDLE:  req_ready_o = 1'b1;
      S_SCAN:  mem_re_o    = rd_en;
      S_FIN:   req_ready_o = 1'b0;
      default: req_ready_o = 1'b0;
    endcase
  end

  assign mem_raddr_o = rd_idx_q[IdxW-1:0];
  assign mem_waddr_o = fill_q[IdxW-1:0];
  assign mem_wdata_o = key_q;

  // Datapath: capture, scan compare, decision and append
  always_comb begin
    op_d     = op_q;
    key_d    = key_q;
    fill_d   = fill_q;
    rd_idx_d = rd_idx_q;
    hit_d    = hit_q;
    res_d    = res_q;
    mem_we_o = 1'b0;

    if (accept) begin
      op_d     = req_op_i;
      key_d    = req_key_i;
      rd_idx_d = '0;
      hit_d    = 1'b0;
      if (req_op_i == OP_CLEAR) begin
        fill_d = '0;
        res_d  = '{matched: 1'b0, status: ST_CLEARED};
      end
    end

    if (rd_en) begin
      rd_idx_d = rd_idx_q + FillW'(1);
    end
    if (rd_vld_q && entry_covers(mem_rdata_i, key_q)) begin
      hit_d = 1'b1;
    end

    // All reads returned: settle the result
    if (scan_done) begin
      if (op_q != OP_INSERT) begin
        res_d = '{matched: hit_q, status: ST_LOOKED};
      end else if (hit_q) begin
        res_d = '{matched: 1'b1, status: ST_COVERED};
      end else if (fill_q >= FillW'(Entries)) begin
        res_d = '{matched: 1'b0, status: ST_FULL};
      end else begin
        res_d    = '{matched: 1'b0, status: ST_INSERT};
        mem_we_o = 1'b1;
        fill_d   = fill_q + FillW'(1);
      end
    end
  end

  // Output register: filled from FIN, drained by the consumer
  always_comb begin
    out_vld_d = out_vld_q;
    out_res_d = out_res_q;
    if (out_vld_q && res_ready_i) begin
      out_vld_d = 1'b0;
    end
    if ((state_q == S_FIN) && out_free) begin
      out_vld_d = 1'b1;
      out_res_d = res_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_vld_q  <= rd_en;
      hit_q     <= hit_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    rd_idx_q  <= rd_idx_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_res_q;

endmodule

>>> src/service_triple_wildcard_filter.sv
// Top level of the service triple wildcard filter.
// Depends on stwf_pkg, stwf_store and stwf_ctrl.
//
// A table of up to TABLE_ENTRIES filter entries, each a triple of 16-bit
// network, stream and service identifiers; a stored zero field matches any
// value. A lookup request reports whether any entry covers the triple, an
// insert stores the triple only when nothing covers it (status full when
// the table has no room) and a clear empties the table. The entries sit in
// a single-port-write, single-port-read memory with registered read data,
// and a request scans the filled part of it one entry per cycle, stopping
// early on a hit. A new request is taken only in idle, after the result of
// the previous one has left the controller. The result sits in an output
// register, so the next request is taken while a result still waits. No
// clearing pass is needed after reset.
module service_triple_wildcard_filter #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // [15:0] network, [31:16] stream,
                                     // [47:32] service
  input  logic [1:0]  s_axis_tuser,  // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] matched, [7:1] zero
  output logic [2:0]  m_axis_tuser   // [2:0] status
);
  import stwf_pkg::*;

  localparam int unsigned IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FillW = $clog2(TABLE_ENTRIES + 1);

  logic [EntryW-1:0] key;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic [EntryW-1:0] mem_rdata;
  res_t              res;

  // Stored layout {network, stream, service}
  assign key = {s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32]};

  stwf_ctrl #(
    .Entries (TABLE_ENTRIES),
    .IdxW    (IdxW),
    .FillW   (FillW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_op_i    (s_axis_tuser),
    .req_key_i   (key),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  stwf_store #(
    .Depth (TABLE_ENTRIES),
    .AddrW (IdxW),
    .DataW (EntryW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tdata = {7'b0, res.matched};
  assign m_axis_tuser = res.status;

endmodule

>>> src/stwf_checker.sv
// Port-level checker for the service triple wildcard filter, with its bind.
// Depends on stwf_pkg.
module stwf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  import stwf_pkg::*;

  // Only one request in the scan at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while previous one still in the scan");

  // Covered status always comes with a match flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_COVERED)) |-> m_axis_tdata[0])
    else $error("covered result without match");

  // Insert, full and clear never report a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == ST_INSERT) || (m_axis_tuser == ST_FULL) ||
                       (m_axis_tuser == ST_CLEARED))) |-> !m_axis_tdata[0])
    else $error("match flag set on a non-matching status");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // A clear request is answered with a cleared status, through FIN and the output register, when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_CLEAR) && !m_axis_tvalid)
      |=> ##1 (m_axis_tvalid && (m_axis_tuser == ST_CLEARED)))
    else $error("clear result missing");

endmodule

bind service_triple_wildcard_filter stwf_checker u_stwf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> dv/tb_service_triple_wildcard_filter.sv
// Self-checking testbench for the service triple wildcard filter table.
// Depends on stwf_pkg and service_triple_wildcard_filter; drives lookup, insert
// and clear requests and compares every result against a table predictor.
`timescale 1ns / 100ps

module tb_service_triple_wildcard_filter;
  import stwf_pkg::*;

  localparam int unsigned TableSize = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;  // unused code, acts as a lookup
  localparam int RandomItems = 1250;
  localparam int HoldoffCycles = 400;
  localparam int MaxGap = 40;

  // Packed so that network sits in the low bits, as on s_axis_tdata
  typedef struct packed {
    logic [15:0] svc;
    logic [15:0] strm;
    logic [15:0] net;
  } triple_t;

  // Table predictor and queue of results still owed by the block
  class filter_scoreboard;
    triple_t entries [TableSize];
    int      fill;
    res_t    owed[$];
    int      n_checked;
    int      n_errors;
    int      n_hits;
    int      op_seen [4];
    int      status_seen [8];

    function new();
      fill = 0;
      n_checked = 0;
      n_errors = 0;
      n_hits = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Stored zero matches anything; a queried zero is an ordinary value
    function bit id_covers(logic [15:0] stored, logic [15:0] query);
      return (stored == 16'd0) || (stored == query);
    endfunction

    // Note an accepted request and work out the result it must produce
    function void note_request(logic [1:0] op, triple_t q);
      res_t r;
      r.matched = 1'b0;
      r.status  = ST_LOOKED;
      op_seen[op]++;
      if (op == OP_CLEAR) begin
        fill = 0;
        r.status = ST_CLEARED;
      end else begin
        for (int i = 0; i < fill; i++) begin
          if (id_covers(entries[i].net, q.net) && id_covers(entries[i].strm, q.strm) &&
              id_covers(entries[i].svc, q.svc))
            r.matched = 1'b1;
        end
        if (op == OP_INSERT) begin
          if (r.matched) begin
            r.status = ST_COVERED;
          end else if (fill >= TableSize) begin
            r.status = ST_FULL;
          end else begin
            entries[fill] = q;
            fill++;
            r.status = ST_INSERT;
          end
        end
      end
      owed = {owed, r};
    endfunction

    // Compare one accepted result with the oldest owed one
    function void check_result(logic matched, logic [2:0] status, logic [6:0] pad);
      res_t r;
      if (owed.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: result with nothing pending: matched=%0b status=%0d",
                   $realtime, matched, status);
      end else begin
        r = owed.pop_front();
        n_checked++;
        status_seen[r.status]++;
        if (r.matched) n_hits++;
        if (matched !== r.matched || status !== r.status || pad !== 7'd0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: mismatch: exp matched=%0b status=%0d, %s=%0b status=%0d pad=%h",
                     $realtime, r.matched, r.status, "got matched", matched, status, pad);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  filter_scoreboard sb;
  int sender_idle_pct;
  int recv_stall_pct;
  int n_holdoff_req;
  int hold_left = 0;
  int n_sent;
  int n_holdoffs = 0;

  service_triple_wildcard_filter #(
    .TABLE_ENTRIES(TableSize)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog
  initial begin
    #10_000_000;
    $display("** service_triple_wildcard_filter: FAILED **");
    $finish;
  end

  // Result side: check, then choose next tready (random stall or long hold-off)
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata[0], m_axis_tuser, m_axis_tdata[7:1]);
      if (n_holdoffs < n_holdoff_req) begin
        hold_left = HoldoffCycles;
        n_holdoffs++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request, with a random idle gap ahead of it
  task automatic send_request(input logic [1:0] op, input triple_t q);
    int gap;
    gap = 0;
    while (($urandom_range(99) < sender_idle_pct) && (gap < MaxGap)) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, q);
    n_sent++;
  endtask

  // Identifier with a chosen share of zeros, a small pool for hits, else random
  function automatic logic [15:0] pick_id(int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return 16'd0;
    if (r < zero_pct + 50) begin
      case ($urandom_range(4))
        0: return 16'd1;
        1: return 16'd2;
        2: return 16'd3;
        3: return 16'h8000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic triple_t mk(logic [15:0] net, logic [15:0] strm, logic [15:0] svc);
    triple_t t;
    t.net  = net;
    t.strm = strm;
    t.svc  = svc;
    return t;
  endfunction

  task automatic set_idle(input int snd, input int rcv);
    sender_idle_pct = snd;
    recv_stall_pct  = rcv;
  endtask

  // Stimulus
  initial begin
    triple_t q;
    triple_t recent[$];
    int      n_directed;
    int      episode;
    int      fill_n;
    int      mix_n;
    int      sel;
    logic [15:0] svc_seq;

    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_LOOKUP;
    n_holdoff_req = 0;
    n_sent = 0;
    svc_seq = 16'd1;
    set_idle(0, 0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, wildcards, zero query, unused code, clear
    send_request(OP_LOOKUP, mk(16'd0, 16'd0, 16'd0));
    send_request(OP_INSERT, mk(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(OP_LOOKUP, mk(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(OP_LOOKUP, mk(16'hFFFF, 16'hFFFF, 16'hFFFE));
    send_request(OP_INSERT, mk(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(OP_INSERT, mk(16'h1234, 16'd0, 16'd0));
    send_request(OP_LOOKUP, mk(16'h1234, 16'hABCD, 16'd1));
    send_request(OP_INSERT, mk(16'h1234, 16'd5, 16'd6));
    send_request(OP_LOOKUP, mk(16'd0, 16'd0, 16'd0));
    send_request(OP_INSERT, mk(16'd0, 16'd0, 16'd5));
    send_request(OP_LOOKUP, mk(16'd0, 16'd0, 16'd5));
    send_request(OP_LOOKUP, mk(16'h5555, 16'hAAAA, 16'd5));
    send_request(OP_UNUSED, mk(16'h1234, 16'd1, 16'd1));
    send_request(OP_UNUSED, mk(16'h4321, 16'd1, 16'd1));
    send_request(OP_INSERT, mk(16'd1, 16'd2, 16'd3));
    send_request(OP_CLEAR,  mk(16'h1234, 16'd1, 16'd1));
    send_request(OP_LOOKUP, mk(16'h1234, 16'd1, 16'd1));
    send_request(OP_INSERT, mk(16'd0, 16'd0, 16'd0));
    send_request(OP_INSERT, mk(16'd7, 16'd7, 16'd7));
    send_request(OP_LOOKUP, mk(16'h8000, 16'h0001, 16'hFFFF));
    send_request(OP_CLEAR,  mk(16'd0, 16'd0, 16'd0));
    n_directed = n_sent;

    // Random episodes: clear, fill with distinct triples, then mixed traffic
    episode = 0;
    while (n_sent < n_directed + RandomItems) begin
      case (episode % 5)
        1: set_idle(69, 0);
        2: set_idle(0, 69);
        3: set_idle(12, 12);
        default: set_idle(0, 0);
      endcase
      if (episode == 2 || episode == 17) n_holdoff_req++;

      send_request(OP_CLEAR, mk(pick_id(30), pick_id(30), pick_id(30)));
      recent.delete();
      fill_n = (episode == 0) ? TableSize + 4 : $urandom_range(TableSize + 8);
      repeat (fill_n) begin
        q = mk(pick_id(0), pick_id(0), svc_seq);
        svc_seq = (svc_seq == 16'hFFFF) ? 16'd1 : svc_seq + 16'd1;
        send_request(OP_INSERT, q);
        recent = {recent, q};
      end

      mix_n = $urandom_range(10, 40);
      repeat (mix_n) begin
        sel = $urandom_range(99);
        if (sel < 35) begin
          if (recent.size() > 0 && $urandom_range(99) < 40)
            q = recent[$urandom_range(recent.size() - 1)];
          else
            q = mk(pick_id(10), pick_id(10), pick_id(10));
          send_request(OP_LOOKUP, q);
        end else if (sel < 70) begin
          q = mk(pick_id(25), pick_id(25), pick_id(25));
          send_request(OP_INSERT, q);
          recent = {recent, q};
        end else if (sel < 80) begin
          send_request(OP_UNUSED, mk(pick_id(10), pick_id(10), pick_id(10)));
        end else begin
          // Noise: any code, fully random identifiers
          send_request(2'($urandom_range(3)),
                       mk(16'($urandom), 16'($urandom), 16'($urandom)));
        end
      end
      episode++;
    end

    // Drain
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Ran %0d requests in %0d episodes (lookup %0d, insert %0d, clear %0d, unused %0d).",
             n_sent, episode, sb.op_seen[OP_LOOKUP], sb.op_seen[OP_INSERT],
             sb.op_seen[OP_CLEAR], sb.op_seen[OP_UNUSED]);
    $display("Checked %0d results: %0d hits, %0d stored, %0d covered, %0d dropped full, %0d errors.",
             sb.n_checked, sb.n_hits, sb.status_seen[ST_INSERT], sb.status_seen[ST_COVERED],
             sb.status_seen[ST_FULL], sb.n_errors);
    if (sb.n_errors == 0)
      $display("** service_triple_wildcard_filter: PASSED **");
    else
      $display("** service_triple_wildcard_filter: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
src/stwf_pkg.sv
src/stwf_store.sv
src/stwf_ctrl.sv
src/service_triple_wildcard_filter.sv
src/stwf_checker.sv
dv/tb_service_triple_wildcard_filter.sv
